// File: hdl/aed_pkg.sv
// Package for the terminal escape decoder: field widths, event and
// screen operation codes, colour remap. No dependencies.
package aed_pkg;

    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 14;
    localparam int POS_W   = 15;

    typedef enum logic [2:0] {
        EV_TEXT   = 3'd0,
        EV_ABS    = 3'd1,
        EV_REL    = 3'd2,
        EV_LINE   = 3'd3,
        EV_SCREEN = 3'd4,
        EV_ATTR   = 3'd5
    } t_event;

    typedef enum logic [3:0] {
        OP_CLR_EOL = 4'd0,
        OP_CLR_SOL = 4'd1,
        OP_CLR_LN  = 4'd2,
        OP_CLR_EOP = 4'd3,
        OP_CLR_SOP = 4'd4,
        OP_PAGE    = 4'd5,
        OP_DELETE  = 4'd6,
        OP_SCROLL  = 4'd7,
        OP_GETCUR  = 4'd8
    } t_op;

    localparam logic [POS_W-1:0] KEEP_ROW    = 15'h4000;
    localparam logic [POS_W-1:0] IGNORE_AXIS = 15'd255;
    localparam logic [7:0]       ESC_CODE    = 8'd27;

    typedef struct packed {
        logic                 kind;
        logic [CHAR_W-1:0]    byte_value;
        logic [POS_W-1:0]     report_x;
        logic [POS_W-1:0]     report_y;
    } t_in;

    typedef struct packed {
        logic [2:0]           event_kind;
        logic [CHAR_W-1:0]    char_code;
        logic [COUNT_W-1:0]   repeat_count;
        logic [POS_W-1:0]     pos_x;
        logic [POS_W-1:0]     pos_y;
        logic [3:0]           screen_op;
        logic [2:0]           foreground;
        logic [2:0]           background;
        logic [4:0]           attr_flags;
        logic                 last_of_run;
    } t_out;

    function automatic logic [2:0] remap(input logic [2:0] c);
        remap = {c[0], c[1], c[2]};
    endfunction

endpackage

// File: hdl/aed_if.sv
// Valid/ready channel interfaces for the escape decoder.
// Depends on aed_pkg.
interface aed_in_if import aed_pkg::*; ();
    logic valid;
    logic ready;
    t_in  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface aed_out_if import aed_pkg::*; ();
    logic valid;
    logic ready;
    t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/ansi_escape_decoder.sv
// Top level of the terminal escape decoder: parser, parameter store and
// the sequencer that walks the stored parameters. Depends on aed_pkg, aed_if.
//
// Usage: items arrive on i_in (one stream byte or one cursor report each)
// and events leave on o_out; every event of an item is delivered before the
// next item is taken, and the final one carries last_of_run. The single
// configuration register newline_only is written through i_cfg_we and
// i_cfg_data. The user must write it only while the block is idle; the block
// itself does nothing to enforce that.
// Sequence: an item is taken in S_IDLE, then the sequencer steps once per
// cycle unless the receiver stalls. A cursor report, or a byte that is
// dropped or only moves the parser on, is finished at the accepting edge.
// A byte inside a sequence then passes through S_DIGIT and the shared
// multiply-by-ten, saturate and compare unit. A final letter goes on to the
// decode state S_CMD; the colour command then walks each stored parameter
// (up to PARAM_SLOTS) in S_COLOR before building its event. Last comes
// S_EMIT, with each event held until the receiver takes it. While the
// receiver stalls, the block holds the event and takes no item.
// Reset clears the parser, stored parameters, cursor fields and colour
// state (keep flags set), and newline_only.
module ansi_escape_decoder
    import aed_pkg::*;
#(
    parameter int PARAM_SLOTS = 12,
    parameter int PARAM_MAX   = 16383
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    aed_in_if.sink      i_in,
    aed_out_if.source   o_out
);

    localparam int CNT_W = $clog2(PARAM_SLOTS + 1);
    localparam int IDX_W = $clog2(PARAM_SLOTS);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(PARAM_SLOTS);
    localparam logic [17:0] MAX_C = 18'(PARAM_MAX);

    typedef enum logic [2:0] {
        S_IDLE, S_DIGIT, S_CMD, S_COLOR, S_EMIT
    } t_state;

    t_state                r_state;
    logic                  r_nl;
    logic [1:0]            r_phase;
    logic [COUNT_W-1:0]    r_slot [PARAM_SLOTS];
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_dig;
    logic [7:0]            r_rep;
    logic                  r_wait;
    logic [POS_W-1:0]      r_sx, r_sy;
    logic [2:0]            r_fg, r_bg;
    logic [4:0]            r_fl;
    logic [7:0]            r_c;
    logic [CNT_W-1:0]      r_i;
    t_out                  r_ev [3];
    logic [1:0]            r_nev;
    logic [1:0]            r_k;

    // Shared unit: one multiply-by-ten, add and saturate on the slot at r_cnt.
    logic [IDX_W-1:0] w_widx;
    logic [17:0]      w_acc;
    logic [COUNT_W-1:0] w_sat;
    assign w_widx = r_cnt[IDX_W-1:0];
    assign w_acc  = 18'(r_slot[w_widx]) * 18'd10 + 18'(r_c - 8'd48);
    assign w_sat  = (w_acc > MAX_C) ? COUNT_W'(PARAM_MAX) : w_acc[COUNT_W-1:0];

    // Parameter reads with a missing slot as zero; w_n is 1 when no parameter is stored.
    logic [COUNT_W-1:0] w_p0, w_p1, w_n, w_cv;
    assign w_p0 = (r_cnt > 0) ? r_slot[0] : '0;
    assign w_p1 = (r_cnt > 1) ? r_slot[1] : '0;
    assign w_n  = (r_cnt != 0) ? w_p0 : COUNT_W'(1);
    assign w_cv = r_slot[r_i[IDX_W-1:0]];

    function automatic t_out ev(input t_event k);
        t_out e;
        e = '0;
        e.event_kind = k;
        return e;
    endfunction

    function automatic logic [POS_W-1:0] mof(input logic [COUNT_W-1:0] v);
        mof = (v == 0) ? '0 : POS_W'(v) - POS_W'(1);
    endfunction

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_EMIT) && (r_nev != 2'd0);
    always_comb begin
        o_out.payload = r_ev[r_k];
        o_out.payload.last_of_run = (r_k == r_nev - 2'd1);
    end

    logic w_letter;
    assign w_letter = (r_c inside {[8'h41:8'h5A], [8'h61:8'h7A]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nl    <= 1'b0;
            r_phase <= 2'd0;
            for (int j = 0; j < PARAM_SLOTS; j++) r_slot[j] <= '0;
            r_cnt   <= '0;
            r_dig   <= 1'b0;
            r_rep   <= '0;
            r_wait  <= 1'b0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_fg    <= '0;
            r_bg    <= '0;
            r_fl    <= 5'h18;
            r_nev   <= '0;
            r_k     <= '0;
            r_i     <= '0;
        end else begin
            if (i_cfg_we) r_nl <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    r_k <= '0;
                    r_nev <= '0;
                    if (i_in.valid) begin
                        r_c <= i_in.payload.byte_value;
                        if (i_in.payload.kind) begin
                            r_sx <= i_in.payload.report_x;
                            r_sy <= i_in.payload.report_y;
                            r_wait <= 1'b0;
                        end else if (!r_wait) begin
                            if (r_phase == 2'd2) begin
                                r_state <= S_DIGIT;
                            end else if (r_phase == 2'd1) begin
                                r_phase <= 2'd0;
                                r_state <= S_EMIT;
                                r_nev <= 2'd1;
                                r_ev[0] <= ev(EV_TEXT);
                                if (i_in.payload.byte_value == 8'h5B) begin
                                    r_phase <= 2'd2;
                                    r_state <= S_IDLE;
                                    r_nev <= 2'd0;
                                end else if (i_in.payload.byte_value == 8'h37 ||
                                             i_in.payload.byte_value == 8'h73) begin
                                    r_ev[0] <= ev(EV_SCREEN);
                                    r_ev[0].screen_op <= OP_GETCUR;
                                    r_wait <= 1'b1;
                                end else if (i_in.payload.byte_value == 8'h38) begin
                                    r_ev[0] <= ev(EV_ABS);
                                    r_ev[0].pos_x <= r_sx;
                                    r_ev[0].pos_y <= r_sy;
                                end else begin
                                    r_ev[0].char_code <= i_in.payload.byte_value;
                                    r_ev[0].repeat_count <= COUNT_W'(1);
                                end
                            end else begin
                                r_state <= S_EMIT;
                                r_nev <= 2'd1;
                                case (i_in.payload.byte_value)
                                    8'h00: begin
                                        r_state <= S_IDLE;
                                        r_nev <= 2'd0;
                                    end
                                    8'h0D: begin
                                        r_ev[0] <= ev(EV_ABS);
                                        r_ev[0].pos_y <= KEEP_ROW;
                                    end
                                    8'h08: begin
                                        r_ev[0] <= ev(EV_REL);
                                        r_ev[0].pos_x <= '1;
                                    end
                                    8'h0A: begin
                                        if (r_nl) begin
                                            r_ev[0] <= ev(EV_ABS);
                                            r_ev[0].pos_y <= KEEP_ROW;
                                            r_ev[1] <= ev(EV_LINE);
                                            r_ev[2] <= ev(EV_REL);
                                            r_ev[2].pos_y <= POS_W'(1);
                                            r_nev <= 2'd3;
                                        end else begin
                                            r_ev[0] <= ev(EV_LINE);
                                            r_ev[1] <= ev(EV_REL);
                                            r_ev[1].pos_y <= POS_W'(1);
                                            r_nev <= 2'd2;
                                        end
                                    end
                                    ESC_CODE: begin
                                        r_phase <= 2'd1;
                                        r_state <= S_IDLE;
                                        r_nev <= 2'd0;
                                    end
                                    default: begin
                                        r_rep <= i_in.payload.byte_value;
                                        r_ev[0] <= ev(EV_TEXT);
                                        r_ev[0].char_code <= i_in.payload.byte_value;
                                        r_ev[0].repeat_count <= COUNT_W'(1);
                                    end
                                endcase
                            end
                        end
                    end
                end
                S_DIGIT: begin
                    r_state <= S_IDLE;
                    if (w_letter) begin
                        if (r_dig) begin
                            r_dig <= 1'b0;
                            if (r_cnt < SLOTS_C) r_cnt <= r_cnt + 1'b1;
                        end
                        r_state <= S_CMD;
                    end else if (r_c inside {[8'h30:8'h39]}) begin
                        if (r_cnt < SLOTS_C) begin
                            r_slot[w_widx] <= w_sat;
                            r_dig <= 1'b1;
                        end
                    end else if (r_c == 8'h3B) begin
                        if (r_dig) begin
                            r_dig <= 1'b0;
                            if (r_cnt < SLOTS_C) begin
                                r_cnt <= r_cnt + 1'b1;
                                if (r_cnt + 1'b1 < SLOTS_C)
                                    r_slot[IDX_W'(r_cnt + 1'b1)] <= '0;
                            end
                        end else if (r_cnt < SLOTS_C) begin
                            r_slot[w_widx] <= '0;
                        end
                    end
                end
                S_CMD: begin
                    r_phase <= 2'd0;
                    r_state <= S_EMIT;
                    r_nev <= 2'd1;
                    r_i <= '0;
                    case (r_c)
                        8'h62: begin
                            r_ev[0] <= ev(EV_TEXT);
                            r_ev[0].char_code <= r_rep;
                            r_ev[0].repeat_count <= w_n;
                            if (w_n == 0) r_nev <= 2'd0;
                        end
                        8'h72: begin
                            r_ev[0] <= ev(EV_SCREEN);
                            r_ev[0].screen_op <= OP_SCROLL;
                            r_ev[0].pos_x <= POS_W'(w_p0);
                            r_ev[0].pos_y <= POS_W'(w_p1);
                        end
                        8'h48, 8'h66: begin
                            r_ev[0] <= ev(EV_ABS);
                            r_ev[0].pos_x <= mof(w_p1);
                            r_ev[0].pos_y <= mof(w_p0);
                        end
                        8'h41: begin
                            r_ev[0] <= ev(EV_REL);
                            r_ev[0].pos_y <= -POS_W'(w_n);
                        end
                        8'h42: begin
                            r_ev[0] <= ev(EV_REL);
                            r_ev[0].pos_y <= POS_W'(w_n);
                        end
                        8'h43: begin
                            r_ev[0] <= ev(EV_REL);
                            r_ev[0].pos_x <= POS_W'(w_n);
                        end
                        8'h44: begin
                            r_ev[0] <= ev(EV_REL);
                            r_ev[0].pos_x <= -POS_W'(w_n);
                        end
                        8'h64: begin
                            r_ev[0] <= ev(EV_ABS);
                            r_ev[0].pos_x <= IGNORE_AXIS;
                            r_ev[0].pos_y <= POS_W'(w_p0);
                        end
                        8'h47: begin
                            r_ev[0] <= ev(EV_ABS);
                            r_ev[0].pos_x <= POS_W'(w_p0);
                            r_ev[0].pos_y <= IGNORE_AXIS;
                        end
                        8'h4A: begin
                            r_ev[0] <= ev(EV_SCREEN);
                            r_ev[0].screen_op <= (w_p0 == 0) ? OP_CLR_EOP :
                                (w_p0 == 1) ? OP_CLR_SOP : OP_PAGE;
                            if (w_p0 > 2) r_nev <= 2'd0;
                        end
                        8'h4B: begin
                            r_ev[0] <= ev(EV_SCREEN);
                            r_ev[0].screen_op <= w_p0[3:0];
                            if (w_p0 > 2) r_nev <= 2'd0;
                        end
                        8'h50: begin
                            r_ev[0] <= ev(EV_SCREEN);
                            r_ev[0].screen_op <= OP_DELETE;
                            r_ev[0].repeat_count <= w_n;
                        end
                        8'h6D: begin
                            r_fl <= 5'h18;
                            r_state <= S_COLOR;
                        end
                        default: r_nev <= 2'd0;
                    endcase
                end
                S_COLOR: begin
                    // One stored parameter per cycle through the compare unit.
                    if (r_i < r_cnt) begin
                        if (w_cv == 0) r_fl <= r_fl | 5'h06;
                        if (w_cv == 1) r_fl <= r_fl | 5'h01;
                        if (w_cv >= 30 && w_cv <= 37) begin
                            r_fl <= r_fl & ~5'h08;
                            r_fg <= remap(w_cv[2:0] - 3'd6);
                        end
                        if (w_cv >= 40 && w_cv <= 47) begin
                            r_fl <= r_fl & ~5'h10;
                            r_bg <= remap(w_cv[2:0]);
                        end
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_ev[0] <= ev(EV_ATTR);
                        r_ev[0].foreground <= r_fg;
                        r_ev[0].background <= r_bg;
                        r_ev[0].attr_flags <= r_fl;
                        r_nev <= 2'd1;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // Clear the parameter store once the letter has been acted on.
                    if (r_phase == 2'd0) begin
                        r_cnt <= '0;
                        for (int j = 0; j < PARAM_SLOTS; j++) r_slot[j] <= '0;
                    end
                    if (r_nev == 2'd0) begin
                        r_state <= S_IDLE;
                    end else if (o_out.ready) begin
                        if (r_k == r_nev - 2'd1) r_state <= S_IDLE;
                        else r_k <= r_k + 2'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= SLOTS_C) else $error("parameter count overflow");
    a_nev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> r_k < r_nev) else $error("event index out of range");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready) else $error("ready while emitting");
endmodule

// File: verif/ansi_escape_decoder_test.sv
// Self-checking testbench for the terminal escape decoder: drives stream bytes
// and cursor reports, predicts events, and compares them. Depends on aed_pkg, aed_if.
module ansi_escape_decoder_test;
    import aed_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS = 12;
    localparam int VALUE_MAX = 16383;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_data = 1'b0;

    aed_in_if  in_ch();
    aed_out_if out_ch();

    ansi_escape_decoder DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source)
    );

    // The clock runs with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the decoder's state, updated as each item is sent.
    logic        lf_returns;
    int          phase;
    int          slot_val [NUM_SLOTS];
    int          slot_count;
    bit          in_digit;
    logic [7:0]  last_char;
    logic [14:0] saved_col, saved_row;
    logic [2:0]  cur_fg, cur_bg;
    bit          await_report;

    t_out events_due[$];
    t_out step_events[$];
    int   failures = 0;
    int   cycle_count = 0;
    int   sender_idle = 0;
    int   receiver_stall = 0;
    bit   hold_off = 1'b0;

    // Idle probability percentages used by the stimulus and the receiver.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_out make_event(t_event k, logic [7:0] ch, int rep, int x, int y,
                                        t_op op, logic [2:0] fg, logic [2:0] bg,
                                        logic [4:0] fl);
        t_out e;
        e.event_kind   = k;
        e.char_code    = ch;
        e.repeat_count = rep[13:0];
        e.pos_x        = x[14:0];
        e.pos_y        = y[14:0];
        e.screen_op    = op;
        e.foreground   = fg;
        e.background   = bg;
        e.attr_flags   = fl;
        e.last_of_run  = 1'b0;
        return e;
    endfunction

    function automatic logic [2:0] colour_swap(int v);
        logic [2:0] c;
        c = v[2:0];
        return {c[0], c[1], c[2]};
    endfunction

    function automatic int slot(int i);
        return (i < slot_count) ? slot_val[i] : 0;
    endfunction

    // The colour command walks every stored parameter in turn.
    task automatic decode_colour();
        logic [4:0] fl;
        fl = 5'h18;
        for (int i = 0; i < slot_count; i++) begin
            if (slot_val[i] == 0) fl |= 5'h06;
            if (slot_val[i] == 1) fl |= 5'h01;
            if (slot_val[i] >= 30 && slot_val[i] <= 37) begin
                fl &= ~5'h08;
                cur_fg = colour_swap(slot_val[i] - 30);
            end
            if (slot_val[i] >= 40 && slot_val[i] <= 47) begin
                fl &= ~5'h10;
                cur_bg = colour_swap(slot_val[i] - 40);
            end
        end
        step_events.push_back(make_event(EV_ATTR, 0, 0, 0, 0, OP_CLR_EOL, cur_fg, cur_bg, fl));
    endtask

    task automatic decode_final(logic [7:0] c);
        int p0, n;
        p0 = slot(0);
        n = (slot_count != 0) ? p0 : 1;
        case (c)
            "b": if (n != 0)
                step_events.push_back(make_event(EV_TEXT, last_char, n, 0, 0, OP_CLR_EOL, 0, 0, 0));
            "r": step_events.push_back(make_event(EV_SCREEN, 0, 0, p0, slot(1), OP_SCROLL, 0, 0, 0));
            "H", "f": step_events.push_back(make_event(EV_ABS, 0, 0,
                (slot(1) == 0) ? 0 : slot(1) - 1, (p0 == 0) ? 0 : p0 - 1, OP_CLR_EOL, 0, 0, 0));
            "A": step_events.push_back(make_event(EV_REL, 0, 0, 0, -n, OP_CLR_EOL, 0, 0, 0));
            "B": step_events.push_back(make_event(EV_REL, 0, 0, 0, n, OP_CLR_EOL, 0, 0, 0));
            "C": step_events.push_back(make_event(EV_REL, 0, 0, n, 0, OP_CLR_EOL, 0, 0, 0));
            "D": step_events.push_back(make_event(EV_REL, 0, 0, -n, 0, OP_CLR_EOL, 0, 0, 0));
            "d": step_events.push_back(make_event(EV_ABS, 0, 0, 255, p0, OP_CLR_EOL, 0, 0, 0));
            "G": step_events.push_back(make_event(EV_ABS, 0, 0, p0, 255, OP_CLR_EOL, 0, 0, 0));
            "J": if (p0 <= 2)
                step_events.push_back(make_event(EV_SCREEN, 0, 0, 0, 0,
                    (p0 == 0) ? OP_CLR_EOP : (p0 == 1) ? OP_CLR_SOP : OP_PAGE, 0, 0, 0));
            "K": if (p0 <= 2)
                step_events.push_back(make_event(EV_SCREEN, 0, 0, 0, 0, t_op'(p0), 0, 0, 0));
            "P": step_events.push_back(make_event(EV_SCREEN, 0, 0, 0, 0, OP_DELETE, 0, 0, 0));
            "m": decode_colour();
            default: ;
        endcase
        if (c == "P") step_events[$].repeat_count = n[13:0];
    endtask

    // Works out the events of one item and queues them as expected.
    task automatic predict_events(t_in it);
        logic [7:0] c;
        c = it.byte_value;
        step_events.delete();
        if (it.kind) begin
            saved_col = it.report_x;
            saved_row = it.report_y;
            await_report = 0;
        end else if (await_report) begin
        end else if (phase == 1) begin
            phase = 0;
            if (c == "[") phase = 2;
            else if (c == "7" || c == "s") begin
                step_events.push_back(make_event(EV_SCREEN, 0, 0, 0, 0, OP_GETCUR, 0, 0, 0));
                await_report = 1;
            end else if (c == "8")
                step_events.push_back(make_event(EV_ABS, 0, 0, int'($signed(saved_col)),
                    int'($signed(saved_row)), OP_CLR_EOL, 0, 0, 0));
            else step_events.push_back(make_event(EV_TEXT, c, 1, 0, 0, OP_CLR_EOL, 0, 0, 0));
        end else if (phase == 2) begin
            if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
                if (in_digit) begin
                    in_digit = 0;
                    if (slot_count < NUM_SLOTS) slot_count++;
                end
                decode_final(c);
                phase = 0;
                slot_count = 0;
                foreach (slot_val[i]) slot_val[i] = 0;
            end else if (c >= "0" && c <= "9") begin
                if (slot_count < NUM_SLOTS) begin
                    slot_val[slot_count] = slot_val[slot_count] * 10 + (c - "0");
                    if (slot_val[slot_count] > VALUE_MAX) slot_val[slot_count] = VALUE_MAX;
                    in_digit = 1;
                end
            end else if (c == ";") begin
                if (in_digit) begin
                    in_digit = 0;
                    if (slot_count < NUM_SLOTS) slot_count++;
                end
                if (slot_count < NUM_SLOTS) slot_val[slot_count] = 0;
            end
        end else begin
            if (c == 0) begin
            end else if (c == 8'h0d)
                step_events.push_back(make_event(EV_ABS, 0, 0, 0, -16384, OP_CLR_EOL, 0, 0, 0));
            else if (c == 8'h08)
                step_events.push_back(make_event(EV_REL, 0, 0, -1, 0, OP_CLR_EOL, 0, 0, 0));
            else if (c == 8'h0a) begin
                if (lf_returns)
                    step_events.push_back(make_event(EV_ABS, 0, 0, 0, -16384, OP_CLR_EOL, 0, 0, 0));
                step_events.push_back(make_event(EV_LINE, 0, 0, 0, 0, OP_CLR_EOL, 0, 0, 0));
                step_events.push_back(make_event(EV_REL, 0, 0, 0, 1, OP_CLR_EOL, 0, 0, 0));
            end else if (c == ESC_CODE) phase = 1;
            else begin
                last_char = c;
                step_events.push_back(make_event(EV_TEXT, c, 1, 0, 0, OP_CLR_EOL, 0, 0, 0));
            end
        end
        if (step_events.size() > 0) step_events[$].last_of_run = 1'b1;
        foreach (step_events[i]) events_due.push_back(step_events[i]);
    endtask

    // Sends one item, idling beforehand as the current phase asks. Valid is
    // left high after the item so that a following item can go straight on;
    // drain() lowers it.
    task automatic send_item(t_in it);
        while ($urandom_range(99) < sender_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        predict_events(it);
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] b);
        t_in it;
        it = '0;
        it.byte_value = b;
        it.report_x = 15'($urandom);
        it.report_y = 15'($urandom);
        send_item(it);
    endtask

    task automatic send_report(int x, int y);
        t_in it;
        it.kind = 1'b1;
        it.byte_value = 8'($urandom);
        it.report_x = x[14:0];
        it.report_y = y[14:0];
        send_item(it);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Stops sending, waits for all expected events, then lets the sequencer settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (events_due.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic set_newline_only(bit v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        lf_returns = v;
    endtask

    // Receiver: stalls at random, or for a long stretch while held off.
    always @(negedge i_clk) begin
        if (hold_off) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= receiver_stall);
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (events_due.size() == 0) begin
                $display("%0t: unexpected event, expected none, actual %p", $time, out_ch.payload);
                failures++;
            end else begin
                want = events_due.pop_front();
                if (out_ch.payload !== want) begin
                    $display("%0t: event mismatch, expected %p, actual %p", $time, want,
                             out_ch.payload);
                    failures++;
                end
            end
        end
    end

    task automatic test_plain_and_controls();
        send_byte(8'h00);
        send_text("A");
        send_byte(8'hff);
        send_byte(8'h0d);
        send_byte(8'h08);
        send_byte(8'h0a);
        send_byte(ESC_CODE);
        send_text("x");
    endtask

    task automatic test_save_restore();
        send_byte(ESC_CODE); send_text("7");
        send_text("zz");
        send_report(-16384, 16383);
        send_byte(ESC_CODE); send_text("8");
        send_byte(ESC_CODE); send_text("s");
        send_report(16383, -16384);
        send_byte(ESC_CODE); send_text("8");
    endtask

    task automatic test_commands();
        send_byte(ESC_CODE); send_text("[5;99999;;7H");
        send_byte(ESC_CODE); send_text("[f");
        send_byte(ESC_CODE); send_text("[0b");
        send_byte(ESC_CODE); send_text("[3bQ");
        send_byte(ESC_CODE); send_text("[2;30r");
        send_byte(ESC_CODE); send_text("[A");
        send_byte(ESC_CODE); send_text("[4B");
        send_byte(ESC_CODE); send_text("[C");
        send_byte(ESC_CODE); send_text("[2D");
        send_byte(ESC_CODE); send_text("[9d");
        send_byte(ESC_CODE); send_text("[8G");
        for (int i = 0; i < 4; i++) begin
            send_byte(ESC_CODE); send_text($sformatf("[%0dJ", i));
            send_byte(ESC_CODE); send_text($sformatf("[%0dK", i));
        end
        send_byte(ESC_CODE); send_text("[3P");
        send_byte(ESC_CODE); send_text("[0;1;31;47;30;40;2;3;4;5;6;7;37m");
        send_byte(ESC_CODE); send_text("[m");
        send_byte(ESC_CODE); send_text("[!q");
    endtask

    function automatic string random_params();
        string s;
        s = "";
        for (int i = $urandom_range(3); i > 0; i--) begin
            case ($urandom_range(3))
                0: s = {s, $sformatf("%0d", $urandom_range(50))};
                1: s = {s, $sformatf("%0d", $urandom_range(99999))};
                2: s = {s, ""};
                default: s = {s, $sformatf("%0d", 30 + $urandom_range(17))};
            endcase
            if (i > 1) s = {s, ";"};
        end
        return s;
    endfunction

    task automatic test_random(int count);
        string letters;
        letters = "HfABCDdGrJKPmbxz";
        for (int sent = 0; sent < count; ) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    string s;
                    s = {"[", random_params(), letters.substr($urandom_range(15),
                         0)};
                    s = {s.substr(0, s.len() - 2), letters[$urandom_range(15)]};
                    send_byte(ESC_CODE);
                    send_text(s);
                    sent += s.len() + 1;
                end
                4: begin
                    send_byte(ESC_CODE);
                    send_text($urandom_range(1) ? "7" : "s");
                    send_byte(8'($urandom));
                    send_report(int'($urandom_range(32767)) - 16384,
                                int'($urandom_range(32767)) - 16384);
                    send_byte(ESC_CODE); send_text("8");
                    sent += 6;
                end
                5: begin
                    send_byte($urandom_range(1) ? 8'h0a : 8'h0d);
                    sent++;
                end
                default: begin
                    send_byte(8'($urandom));
                    sent++;
                end
            endcase
        end
    endtask

    // Holds the receiver off long enough for the decoder to back up.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(negedge i_clk);
                hold_off = 1'b0;
            end
            send_text("abcdefgh\n\n");
        join
    endtask

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        lf_returns = 0; phase = 0; slot_count = 0; in_digit = 0; last_char = 0;
        saved_col = 0; saved_row = 0; cur_fg = 0; cur_bg = 0; await_report = 0;
        foreach (slot_val[i]) slot_val[i] = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_and_controls();
        test_save_restore();
        test_commands();
        set_newline_only(1'b1);
        send_byte(8'h0a);
        test_random(5);
        sender_idle = 47;
        set_newline_only(1'b0);
        test_random(5);
        sender_idle = 0; receiver_stall = 47;
        set_newline_only(1'b1);
        test_random(5);
        sender_idle = 10; receiver_stall = 10;
        test_random(5);
        sender_idle = 0; receiver_stall = 0;
        test_backpressure();
        set_newline_only(1'b0);
        send_byte(8'h0a);
        drain();

        if (failures == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule

// File: sim.f
hdl/aed_pkg.sv
hdl/aed_if.sv
hdl/ansi_escape_decoder.sv
verif/ansi_escape_decoder_test.sv
